// ----- design/hsl_to_rgb_integer_defines.svh -----
// ----------------------------------------------------------------------------
// HSL to RGB converter: assertion macros
// Clocked, reset-qualified assertion wrappers for the converter's checks.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_INTEGER_DEFINES_SVH
`define HSL_TO_RGB_INTEGER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define H2R_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("h2r: check failed");

`define H2R_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("h2r: check failed");

`else

`define H2R_ASSERT(lbl, cond)

`define H2R_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- design/h2r_pkg.sv -----
// ----------------------------------------------------------------------------
// HSL to RGB converter: package
// Widths, constants, types and hue helpers shared by the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package h2r_pkg;

	localparam int unsigned HUE_W   = 10;
	localparam int unsigned PCT_W   = 7;
	localparam int unsigned LVL_W   = 8;
	localparam int unsigned DEG_W   = 9;
	localparam int unsigned MIX_W   = 15;
	localparam int unsigned BAND_W  = 14;
	localparam int unsigned SPAN_W  = 6;
	localparam int unsigned RAMP_W  = 20;
	localparam int unsigned RECIP_W = 29;
	localparam int unsigned PROD_W  = RAMP_W + RECIP_W;
	localparam int unsigned RECIP_SHIFT = 40;
	localparam int unsigned CH_NUM  = 3;

	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 2;

	localparam logic [HUE_W-1:0]  HUE_TURN     = HUE_W'(360);
	localparam logic [HUE_W-1:0]  HUE_TWO_TURN = HUE_W'(720);
	localparam logic [DEG_W-1:0]  RED_OFFS     = DEG_W'(120);
	localparam logic [DEG_W-1:0]  BLUE_OFFS    = DEG_W'(240);
	localparam logic [DEG_W-1:0]  SEG_RISE_END = DEG_W'(60);
	localparam logic [DEG_W-1:0]  SEG_FLAT_END = DEG_W'(180);
	localparam logic [DEG_W-1:0]  SEG_FALL_END = DEG_W'(240);
	localparam logic [SPAN_W-1:0] SPAN_FULL    = SPAN_W'(60);
	localparam logic [PCT_W-1:0]  PCT_FULL     = PCT_W'(100);
	localparam logic [PCT_W-1:0]  PCT_HALF     = PCT_W'(50);
	localparam logic [MIX_W-1:0]  MIX_HUNDRED  = MIX_W'(100);
	localparam logic [MIX_W-1:0]  MIX_TWO_HUND = MIX_W'(200);
	localparam logic [MIX_W-1:0]  MIX_FULL     = MIX_W'(10000);
	localparam logic [RAMP_W-1:0] RAMP_SIXTY   = RAMP_W'(60);
	localparam logic [RAMP_W-1:0] RAMP_MAX     = RAMP_W'(600000);
	// floor(x * 17 / 40000) == (x * RECIP) >> RECIP_SHIFT for x up to RAMP_MAX
	localparam logic [RECIP_W-1:0] RECIP       = RECIP_W'(467292442);

	typedef logic [DEG_W-1:0]  deg_t;
	typedef logic [PCT_W-1:0]  pct_t;
	typedef logic [BAND_W-1:0] band_t;
	typedef logic [SPAN_W-1:0] span_t;
	typedef logic [RAMP_W-1:0] ramp_t;
	typedef logic [PROD_W-1:0] prod_t;

	function automatic deg_t hue_wrap_add(deg_t h, deg_t offs);
		logic [HUE_W-1:0] s;
		s = HUE_W'(h) + HUE_W'(offs);
		if (s >= HUE_TURN) begin
			s = s - HUE_TURN;
		end
		return s[DEG_W-1:0];
	endfunction

	function automatic span_t ramp_pos(deg_t h);
		deg_t d;
		d = SEG_FALL_END - h;
		if (h < SEG_RISE_END) begin
			return h[SPAN_W-1:0];
		end else if (h < SEG_FLAT_END) begin
			return SPAN_FULL;
		end else if (h < SEG_FALL_END) begin
			return d[SPAN_W-1:0];
		end else begin
			return '0;
		end
	endfunction

	function automatic pct_t pct_clamp(pct_t p);
		return (p > PCT_FULL) ? PCT_FULL : p;
	endfunction

endpackage

// ----- design/hsl_to_rgb_integer.sv -----
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Integer hue/saturation/lightness to 8-bit red, green and blue, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries hue_deg, sat_pct and light_pct.
//   Output channel out_valid/out_ready carries red_level, green_level and
//   blue_level, one result transaction per input transaction, in order.
//   Throughput is one transaction per cycle while the receiver does not
//   stall; the result passes through four register stages: input clamp
//   and hue reduction, light-band mixing, hue ramp multiply-add, and the
//   reciprocal multiply whose top bits form the levels.
//   Zero saturation needs no separate path: both bands equal the grey level.
//   Reset clears the stage valid bits only; the pipeline starts empty.
//   When the receiver stalls with a result waiting, every stage holds,
//   empty stages included, and in_ready drops.
//   No storage beyond the pipeline registers; nothing to configure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hsl_to_rgb_integer_defines.svh"

module hsl_to_rgb_integer
	import h2r_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [HUE_W-1:0] hue_deg,
	input  logic [PCT_W-1:0] sat_pct,
	input  logic [PCT_W-1:0] light_pct,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [LVL_W-1:0] red_level,
	output logic [LVL_W-1:0] green_level,
	output logic [LVL_W-1:0] blue_level
);

	logic en;

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	deg_t hue_s1;
	pct_t sat_s1, lit_s1;

	band_t lo_s2, diff_s2;
	span_t [CH_NUM-1:0] t_s2;

	ramp_t [CH_NUM-1:0] ramp_s3;

	prod_t [CH_NUM-1:0] prod_s4;

	logic [HUE_W-1:0] hue_red;
	logic [MIX_W-1:0] lit_w, sat_w, hi_a, hi_b, hi_c, l200_c, lo_c, diff_c;
	deg_t [CH_NUM-1:0] pt_c;
	ramp_t [CH_NUM-1:0] ramp_c;

	assign en       = !valid_s4 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage 1: reduce hue, clamp percentages
	always_comb begin
		if (hue_deg >= HUE_TWO_TURN) begin
			hue_red = hue_deg - HUE_TWO_TURN;
		end else if (hue_deg >= HUE_TURN) begin
			hue_red = hue_deg - HUE_TURN;
		end else begin
			hue_red = hue_deg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s1 <= hue_red[DEG_W-1:0];
			sat_s1 <= pct_clamp(sat_pct);
			lit_s1 <= pct_clamp(light_pct);
		end
	end

	// stage 2: light bands and ramp positions
	always_comb begin
		lit_w  = MIX_W'(lit_s1);
		sat_w  = MIX_W'(sat_s1);
		hi_a   = lit_w * (MIX_HUNDRED + sat_w);
		hi_b   = (lit_w + sat_w) * MIX_HUNDRED - sat_w * lit_w;
		hi_c   = (lit_s1 < PCT_HALF) ? hi_a : hi_b;
		l200_c = lit_w * MIX_TWO_HUND;
		lo_c   = l200_c - hi_c;
		diff_c = hi_c - lo_c;
		pt_c[CH_RED]   = hue_wrap_add(hue_s1, RED_OFFS);
		pt_c[CH_GREEN] = hue_s1;
		pt_c[CH_BLUE]  = hue_wrap_add(hue_s1, BLUE_OFFS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2   <= lo_c[BAND_W-1:0];
			diff_s2 <= diff_c[BAND_W-1:0];
			for (int c = 0; c < CH_NUM; c++) begin
				t_s2[c] <= ramp_pos(pt_c[c]);
			end
		end
	end

	// stage 3: ramp = lo*60 + (hi-lo)*t
	always_comb begin
		for (int c = 0; c < CH_NUM; c++) begin
			ramp_c[c] = RAMP_W'(lo_s2) * RAMP_SIXTY + RAMP_W'(diff_s2) * RAMP_W'(t_s2[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ramp_s3 <= ramp_c;
		end
	end

	// stage 4: scale by 255/600000 through a reciprocal multiply
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < CH_NUM; c++) begin
				prod_s4[c] <= PROD_W'(ramp_s3[c]) * PROD_W'(RECIP);
			end
		end
	end

	assign out_valid   = valid_s4;
	assign red_level   = prod_s4[CH_RED][RECIP_SHIFT +: LVL_W];
	assign green_level = prod_s4[CH_GREEN][RECIP_SHIFT +: LVL_W];
	assign blue_level  = prod_s4[CH_BLUE][RECIP_SHIFT +: LVL_W];

	`H2R_ASSERT_NEXT(a_enter_s1, in_valid && in_ready, valid_s1)
	`H2R_ASSERT(a_band_bound, !valid_s2 || (MIX_W'(lo_s2) + MIX_W'(diff_s2) <= MIX_FULL))
	`H2R_ASSERT(a_ramp_bound, !valid_s3 || ((ramp_s3[CH_RED] <= RAMP_MAX)
		&& (ramp_s3[CH_GREEN] <= RAMP_MAX) && (ramp_s3[CH_BLUE] <= RAMP_MAX)))

endmodule

// ----- dv/hsl_to_rgb_integer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Drives hue, saturation and lightness transactions through the converter and
// checks every red, green and blue level against an integer colour predictor.
// Runs directed corner cases, then random pixels under several idling mixes.
// ----------------------------------------------------------------------------

module hsl_to_rgb_integer_tb;
	import h2r_pkg::*;

	localparam int unsigned QUIET_LIMIT   = 5000;
	localparam int unsigned DRAIN_CYCLES  = 12;
	localparam int unsigned PHASE_PIXELS  = 132;
	localparam int unsigned HUE_CIRCLE    = 360;
	localparam int unsigned PCT_CEILING   = 100;
	localparam int unsigned LEVEL_SCALE   = 255;
	localparam int unsigned RAMP_DIVISOR  = 600000;

	typedef struct packed {
		logic [LVL_W-1:0] red;
		logic [LVL_W-1:0] green;
		logic [LVL_W-1:0] blue;
	} rgb_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [HUE_W-1:0] hue_deg = '0;
	logic [PCT_W-1:0] sat_pct = '0;
	logic [PCT_W-1:0] light_pct = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [LVL_W-1:0] red_level;
	logic [LVL_W-1:0] green_level;
	logic [LVL_W-1:0] blue_level;

	rgb_t        rgb_expected[$];
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;

	hsl_to_rgb_integer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.hue_deg    (hue_deg),
		.sat_pct    (sat_pct),
		.light_pct  (light_pct),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red_level  (red_level),
		.green_level(green_level),
		.blue_level (blue_level)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [LVL_W-1:0] ramp_level(int unsigned lo, int unsigned hi,
			int unsigned deg);
		int unsigned ramp;
		if (deg < 60) begin
			ramp = lo * 60 + (hi - lo) * deg;
		end else if (deg < 180) begin
			ramp = hi * 60;
		end else if (deg < 240) begin
			ramp = lo * 60 + (hi - lo) * (240 - deg);
		end else begin
			ramp = lo * 60;
		end
		return LVL_W'(ramp * LEVEL_SCALE / RAMP_DIVISOR);
	endfunction

	function automatic rgb_t predict_rgb(logic [HUE_W-1:0] h_in, logic [PCT_W-1:0] s_in,
			logic [PCT_W-1:0] l_in);
		int unsigned h, s, l, hi, lo;
		rgb_t        c;
		h = h_in % HUE_CIRCLE;
		s = (s_in > PCT_CEILING) ? PCT_CEILING : s_in;
		l = (l_in > PCT_CEILING) ? PCT_CEILING : l_in;
		if (s == 0) begin
			c.red   = LVL_W'(l * LEVEL_SCALE / PCT_CEILING);
			c.green = c.red;
			c.blue  = c.red;
		end else begin
			if (l < 50) begin
				hi = l * (100 + s);
			end else begin
				hi = (l + s) * 100 - s * l;
			end
			lo = l * 200 - hi;
			c.red   = ramp_level(lo, hi, (h + 120) % HUE_CIRCLE);
			c.green = ramp_level(lo, hi, h);
			c.blue  = ramp_level(lo, hi, (h + 240) % HUE_CIRCLE);
		end
		return c;
	endfunction

	task automatic check_level(input string field, input logic [LVL_W-1:0] want,
			input logic [LVL_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			error_count++;
		end
	endtask

	// Compare results, record accepted inputs and watch for a hang.
	always @(posedge clk) begin
		rgb_t want;
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (rgb_expected.size() == 0) begin
					$error("result transaction with nothing expected");
					error_count++;
				end else begin
					want = rgb_expected.pop_front();
					check_level("red_level", want.red, red_level);
					check_level("green_level", want.green, green_level);
					check_level("blue_level", want.blue, blue_level);
				end
			end
			if (in_valid && in_ready) begin
				rgb_expected.push_back(predict_rgb(hue_deg, sat_pct, light_pct));
			end
			if ((out_valid && out_ready) || (in_valid && in_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [PCT_W-1:0] s,
			input logic [PCT_W-1:0] l);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid  <= 1'b0;
			hue_deg   <= HUE_W'($urandom);
			sat_pct   <= PCT_W'($urandom);
			light_pct <= PCT_W'($urandom);
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		hue_deg   <= h;
		sat_pct   <= s;
		light_pct <= l;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic random_pixels(input int unsigned count);
		logic [HUE_W-1:0] h;
		logic [PCT_W-1:0] s;
		logic [PCT_W-1:0] l;
		int unsigned      pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				h = HUE_W'($urandom_range(HUE_CIRCLE - 1));
				s = PCT_W'($urandom_range(PCT_CEILING));
				l = PCT_W'($urandom_range(PCT_CEILING));
			end else if (pick < 75) begin
				h = HUE_W'($urandom);
				s = '0;
				l = PCT_W'($urandom);
			end else begin
				h = HUE_W'($urandom);
				s = PCT_W'($urandom);
				l = PCT_W'($urandom);
			end
			send_pixel(h, s, l);
		end
	endtask

	task automatic test_hue_segments_and_clamps();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_pixel(10'd0, 7'd100, 7'd50);
		send_pixel(10'd59, 7'd100, 7'd50);
		send_pixel(10'd60, 7'd100, 7'd50);
		send_pixel(10'd119, 7'd100, 7'd50);
		send_pixel(10'd120, 7'd100, 7'd50);
		send_pixel(10'd179, 7'd100, 7'd50);
		send_pixel(10'd180, 7'd100, 7'd50);
		send_pixel(10'd239, 7'd100, 7'd50);
		send_pixel(10'd240, 7'd100, 7'd50);
		send_pixel(10'd359, 7'd100, 7'd50);
		send_pixel(10'd360, 7'd100, 7'd50);
		send_pixel(10'd719, 7'd80, 7'd30);
		send_pixel(10'd720, 7'd100, 7'd50);
		send_pixel(10'd1023, 7'd127, 7'd127);
		send_pixel(10'd0, 7'd0, 7'd0);
		send_pixel(10'd200, 7'd0, 7'd100);
		send_pixel(10'd1023, 7'd0, 7'd127);
		send_pixel(10'd30, 7'd1, 7'd1);
		send_pixel(10'd300, 7'd101, 7'd49);
		send_pixel(10'd90, 7'd50, 7'd50);
		send_pixel(10'd150, 7'd127, 7'd0);
		send_pixel(10'd10, 7'd100, 7'd100);
		send_pixel(10'd545, 7'd64, 7'd99);
	endtask

	task automatic test_steady_stream();
		send_idle_pct = 0;
		stall_pct     = 0;
		random_pixels(PHASE_PIXELS);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 45;
		stall_pct     = 0;
		random_pixels(PHASE_PIXELS);
	endtask

	task automatic test_receiver_backpressure();
		send_idle_pct = 0;
		stall_pct     = 45;
		random_pixels(PHASE_PIXELS);
	endtask

	task automatic test_mixed_idling();
		send_idle_pct = 28;
		stall_pct     = 28;
		random_pixels(PHASE_PIXELS);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_hue_segments_and_clamps();
		test_steady_stream();
		test_sender_gaps();
		test_receiver_backpressure();
		test_mixed_idling();
		in_valid <= 1'b0;
		while (rgb_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (rgb_expected.size() != 0) begin
			$error("%0d expected results never arrived", rgb_expected.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
